### rtl/twod_pkg.sv
// shared types, constants and helpers of the three-wheel omni odometry block
package twod_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MULW = 32;
	localparam int DIVW = 58;

	localparam logic signed [63:0] INV_SQRT3_Q32 = 64'sd2479700525;
	localparam logic signed [63:0] PI_Q30 = 64'sd3373259426;
	localparam logic signed [63:0] INV_TWO_PI_Q28 = 64'sd42722830;
	localparam logic signed [63:0] SPEED_SCALE = 64'sd1000000;
	localparam logic [31:0] MIN_DT_US = 32'd100;

	localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
	localparam logic [1:0] REG_CENTER_DIST = 2'd1;
	localparam logic [1:0] REG_WINDOW_LEN = 2'd2;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_INIT = 1'b1;

	typedef struct packed {
		logic operation;
		logic signed [19:0] wheel_a_step;
		logic signed [19:0] wheel_b_step;
		logic signed [19:0] wheel_c_step;
		logic [31:0] time_us;
	} wheel_req_t;

	typedef struct packed {
		logic accepted;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [23:0] heading_angle;
		logic signed [31:0] speed_x;
		logic signed [31:0] speed_y;
		logic signed [31:0] turn_rate;
		logic signed [31:0] travel_a;
		logic signed [31:0] travel_b;
		logic signed [31:0] travel_c;
	} odom_rsp_t;

	typedef struct packed {
		logic start;
		logic is_div;
		logic rnd;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} arith_cmd_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] res;
	} arith_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) r = 32'sh7fffffff;
		else if (x < -64'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage

### rtl/twod_stream_if.sv
// valid/ready stream channel with a typed payload
interface twod_stream_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### rtl/twod_ram.sv
// generic single-write, single-read ram with registered read data
module twod_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### rtl/twod_arith.sv
// bit-serial shared multiplier and restoring divider
module twod_arith
	import twod_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input arith_cmd_t cmd,
	output arith_rsp_t rsp
);
	logic busy_q, done_q, div_q, neg_q;
	logic [5:0] cnt_q;
	logic [63:0] acc_q, mcand_q;
	logic [MULW-1:0] mplier_q;
	logic [DIVW-1:0] quo_q;
	logic [31:0] rem_q, dsr_q;
	logic [63:0] a_u, b_u, a_mag, b_mag, mag;
	logic [32:0] trial;
	logic trial_ge;

	assign a_u = cmd.a;
	assign b_u = cmd.b;
	assign a_mag = a_u[63] ? (~a_u + 64'd1) : a_u;
	assign b_mag = b_u[63] ? (~b_u + 64'd1) : b_u;
	assign trial = {rem_q, quo_q[DIVW-1]};
	assign trial_ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= cmd.is_div ? 6'(DIVW) : 6'(MULW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_q <= cmd.is_div;
			rem_q <= '0;
			dsr_q <= b_u[31:0];
			mcand_q <= a_u;
			acc_q <= '0;
			mplier_q <= b_mag[MULW-1:0];
			if (cmd.is_div) begin
				neg_q <= a_u[63];
				quo_q <= a_mag[DIVW-1:0] + (cmd.rnd ? DIVW'(b_u[31:1]) : '0);
			end else begin
				neg_q <= b_u[63];
				quo_q <= '0;
			end
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= trial_ge ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
				quo_q <= {quo_q[DIVW-2:0], trial_ge};
			end else begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
		end
	end

	// sign applied once the magnitude is complete
	assign mag = div_q ? 64'(quo_q) : acc_q;
	assign rsp.res = neg_q ? (~mag + 64'd1) : mag;
	assign rsp.done = done_q;
endmodule

### rtl/three_wheel_omni_odometry.sv
// top level: three-wheel omni base odometry with rolling speed means
//
// requests arrive on the wheel channel (valid/ready): an update carries three
// wheel angle steps and a timestamp, an init clears the speed means and sets
// the time reference. every request gives exactly one result on the odom
// channel: pose, heading, rolling mean speeds and the per-wheel travel sums.
// configuration (radius, center distance, window) goes in on the cfg port;
// the user must write it only while the block is idle, the block does not
// enforce this. writing the window also clears the means. all arithmetic
// goes through one bit-serial unit: an accepted update with a nonzero center
// distance runs 29 multiplies and 25 divides, most of them for the 16-term
// sine/cosine series. one request is worked on at a time; the next is taken
// as soon as the result is parked in the output register, so a stalled
// receiver only holds up the block when a second result is ready to leave.
// reset clears pose, travel, time reference, means and config (window 16);
// the speed ring needs no clearing since entries are only read once written
// after the last clear
module three_wheel_omni_odometry
	import twod_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	twod_stream_if.sink wheel,
	twod_stream_if.source odom
);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SW = 33 + $clog2(WINDOW_MAX);

	// sequencer states
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_VMUL = 5'd1;
	localparam logic [4:0] ST_DXMUL = 5'd2;
	localparam logic [4:0] ST_DYDIV = 5'd3;
	localparam logic [4:0] ST_DTHDIV = 5'd4;
	localparam logic [4:0] ST_HMUL = 5'd5;
	localparam logic [4:0] ST_HDIV = 5'd6;
	localparam logic [4:0] ST_CHECK = 5'd7;
	localparam logic [4:0] ST_XMUL = 5'd8;
	localparam logic [4:0] ST_TMUL = 5'd9;
	localparam logic [4:0] ST_TDIV = 5'd10;
	localparam logic [4:0] ST_FOLD = 5'd11;
	localparam logic [4:0] ST_RMUL = 5'd12;
	localparam logic [4:0] ST_SMUL = 5'd13;
	localparam logic [4:0] ST_SDIV = 5'd14;
	localparam logic [4:0] ST_RDREQ = 5'd15;
	localparam logic [4:0] ST_PUSH = 5'd16;
	localparam logic [4:0] ST_MDIV = 5'd17;
	localparam logic [4:0] ST_DONE = 5'd18;

	logic [4:0] state_q;
	logic wait_q;
	logic [1:0] k_q;
	logic [4:0] n_q;

	// configuration
	logic [15:0] radius_q, center_q;
	logic [6:0] window_q;

	// persistent state
	logic signed [31:0] pose_x_q, pose_y_q;
	logic [23:0] heading_q;
	logic [31:0] travel_q [3];
	logic [31:0] last_time_q;
	logic signed [SW-1:0] sums_q [3];
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;

	// per-request working registers
	wheel_req_t req_q;
	logic signed [20:0] v_q [3];
	logic signed [21:0] dx_q, dy_q;
	logic signed [39:0] dth_q;
	logic [23:0] hstep_q;
	logic signed [63:0] tmp_q;
	logic [30:0] x_q;
	logic [31:0] p_q;
	logic signed [33:0] sin_q, cos_q;
	logic [31:0] dt_q;
	logic signed [31:0] smp_q [3];
	logic signed [31:0] mean_q [3];
	logic accepted_q;

	// output register
	odom_rsp_t out_q;
	logic out_valid_q;

	arith_cmd_t ar_cmd;
	arith_rsp_t ar_rsp;
	logic fin;

	logic [31:0] ring_rdata [3];
	logic [CW-1:0] win_eff;
	logic [IW-1:0] idx_norm, idx_next;
	logic full;

	logic signed [19:0] step_sel;
	logic signed [63:0] v1w, v2w, v3w, vsum, l3, l48;
	logic signed [63:0] vr, dr;
	logic signed [20:0] v_new;
	logic signed [63:0] rot_a, rot_b, smp_a;
	logic signed [63:0] rot_sum, rot_inc;
	logic signed [31:0] pose_sel, pose_new;
	logic [31:0] dt_now;
	logic [31:0] p_new;
	logic signed [33:0] term;
	logic out_free;

	twod_arith u_arith (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(ar_cmd),
		.rsp(ar_rsp)
	);

	// one ring per speed component
	for (genvar g = 0; g < 3; g++) begin : g_ring
		twod_ram #(
			.WIDTH(32),
			.DEPTH(WINDOW_MAX)
		) u_ring (
			.clk(clk),
			.we(state_q == ST_PUSH),
			.waddr(idx_q),
			.wdata(smp_q[g]),
			.raddr(idx_norm),
			.rdata(ring_rdata[g])
		);
	end

	// window clamped to 1..WINDOW_MAX
	always_comb begin
		if (window_q == '0) win_eff = CW'(1);
		else if (32'(window_q) > WINDOW_MAX) win_eff = CW'(WINDOW_MAX);
		else win_eff = CW'(window_q);
	end

	assign idx_norm = (CW'(idx_q) >= win_eff) ? '0 : idx_q;
	assign idx_next = (CW'(idx_q) + CW'(1) >= win_eff) ? '0 : idx_q + IW'(1);
	assign full = count_q >= win_eff;

	// wheel reorder: v1 = b, v2 = c, v3 = a
	always_comb begin
		case (k_q)
			2'd0: step_sel = req_q.wheel_b_step;
			2'd1: step_sel = req_q.wheel_c_step;
			default: step_sel = req_q.wheel_a_step;
		endcase
	end

	assign v1w = 64'(v_q[0]);
	assign v2w = 64'(v_q[1]);
	assign v3w = 64'(v_q[2]);
	assign vsum = v1w + v2w + v3w;
	assign l3 = (64'(center_q) << 1) + 64'(center_q);
	assign l48 = (64'(center_q) << 5) + (64'(center_q) << 4);

	// round half up after the radius and 1/sqrt3 scalings
	assign vr = ar_rsp.res + 64'sd32768;
	assign v_new = vr[36:16];
	assign dr = ar_rsp.res + 64'sd2147483648;

	// rotation operands: dx*cos, dy*sin, dy*cos, dx*sin
	assign rot_a = (k_q inside {2'd0, 2'd3}) ? 64'(dx_q) : 64'(dy_q);
	assign rot_b = (k_q inside {2'd0, 2'd2}) ? 64'(cos_q) : 64'(sin_q);
	assign rot_sum = (k_q == 2'd1) ? (tmp_q - ar_rsp.res) : (tmp_q + ar_rsp.res);
	assign rot_inc = (rot_sum + 64'sd536870912) >>> 30;
	assign pose_sel = (k_q == 2'd1) ? pose_x_q : pose_y_q;
	assign pose_new = sat32(64'(pose_sel) + rot_inc);

	always_comb begin
		case (k_q)
			2'd0: smp_a = 64'(dx_q);
			2'd1: smp_a = 64'(dy_q);
			default: smp_a = 64'(dth_q);
		endcase
	end

	assign dt_now = req_q.time_us - last_time_q;

	// taylor term and its sign
	assign p_new = ar_rsp.res[31:0];
	assign term = n_q[1] ? -34'(signed'({2'b00, p_new})) : 34'(signed'({2'b00, p_new}));

	assign fin = wait_q && ar_rsp.done;

	// operand selection for the serial unit
	always_comb begin
		ar_cmd = '0;
		case (state_q)
			ST_VMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = 64'(step_sel);
				ar_cmd.b = 64'(radius_q);
			end
			ST_DXMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = v1w - v2w;
				ar_cmd.b = INV_SQRT3_Q32;
			end
			ST_DYDIV: begin
				ar_cmd.start = !wait_q;
				ar_cmd.is_div = 1'b1;
				ar_cmd.rnd = 1'b1;
				ar_cmd.a = v1w + v2w - (v3w <<< 1);
				ar_cmd.b = 64'sd3;
			end
			ST_DTHDIV: begin
				ar_cmd.start = !wait_q;
				ar_cmd.is_div = 1'b1;
				ar_cmd.rnd = 1'b1;
				ar_cmd.a = vsum <<< FRAC_BITS;
				ar_cmd.b = l3;
			end
			ST_HMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = vsum;
				ar_cmd.b = INV_TWO_PI_Q28;
			end
			ST_HDIV: begin
				ar_cmd.start = !wait_q;
				ar_cmd.is_div = 1'b1;
				ar_cmd.rnd = 1'b1;
				ar_cmd.a = tmp_q;
				ar_cmd.b = l48;
			end
			ST_XMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = 64'(heading_q[21:0]);
				ar_cmd.b = PI_Q30;
			end
			ST_TMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = 64'(p_q);
				ar_cmd.b = 64'(x_q);
			end
			ST_TDIV: begin
				ar_cmd.start = !wait_q;
				ar_cmd.is_div = 1'b1;
				ar_cmd.a = tmp_q >>> 30;
				ar_cmd.b = 64'(n_q);
			end
			ST_RMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = rot_a;
				ar_cmd.b = rot_b;
			end
			ST_SMUL: begin
				ar_cmd.start = !wait_q;
				ar_cmd.a = smp_a;
				ar_cmd.b = SPEED_SCALE;
			end
			ST_SDIV: begin
				ar_cmd.start = !wait_q;
				ar_cmd.is_div = 1'b1;
				ar_cmd.rnd = 1'b1;
				ar_cmd.a = tmp_q;
				ar_cmd.b = 64'(dt_q);
			end
			ST_MDIV: begin
				ar_cmd.start = !wait_q && (count_q != '0);
				ar_cmd.is_div = 1'b1;
				ar_cmd.rnd = 1'b1;
				ar_cmd.a = 64'(sums_q[k_q]);
				ar_cmd.b = 64'(count_q);
			end
			default: ar_cmd = '0;
		endcase
	end

	assign out_free = !out_valid_q || odom.ready;
	assign wheel.ready = (state_q == ST_IDLE);
	assign odom.valid = out_valid_q;
	assign odom.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
			radius_q <= '0;
			center_q <= '0;
			window_q <= 7'd16;
			pose_x_q <= '0;
			pose_y_q <= '0;
			heading_q <= '0;
			for (int i = 0; i < 3; i++) begin
				travel_q[i] <= '0;
				sums_q[i] <= '0;
			end
			last_time_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ar_cmd.start) wait_q <= 1'b1;
			if (fin) wait_q <= 1'b0;
			// a new result parked in the same cycle keeps the valid high
			if (odom.valid && odom.ready && !(state_q == ST_DONE && out_free))
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (wheel.valid) begin
						req_q <= wheel.payload;
						accepted_q <= 1'b0;
						k_q <= '0;
						if (wheel.payload.operation == OP_INIT) begin
							for (int i = 0; i < 3; i++) sums_q[i] <= '0;
							count_q <= '0;
							idx_q <= '0;
							last_time_q <= wheel.payload.time_us;
							state_q <= ST_MDIV;
						end else begin
							state_q <= ST_VMUL;
						end
					end
				end
				ST_VMUL: begin
					if (fin) begin
						v_q[k_q] <= v_new;
						travel_q[k_q] <= travel_q[k_q] + 32'(v_new);
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= ST_DXMUL;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				ST_DXMUL: begin
					if (fin) begin
						dx_q <= dr[53:32];
						state_q <= ST_DYDIV;
					end
				end
				ST_DYDIV: begin
					if (fin) begin
						dy_q <= ar_rsp.res[21:0];
						// no wheel center distance: no turn at all
						if (center_q == '0) begin
							dth_q <= '0;
							hstep_q <= '0;
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_DTHDIV;
						end
					end
				end
				ST_DTHDIV: begin
					if (fin) begin
						dth_q <= ar_rsp.res[39:0];
						state_q <= ST_HMUL;
					end
				end
				ST_HMUL: begin
					if (fin) begin
						tmp_q <= ar_rsp.res;
						state_q <= ST_HDIV;
					end
				end
				ST_HDIV: begin
					if (fin) begin
						hstep_q <= ar_rsp.res[23:0];
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					dt_q <= dt_now;
					if (dt_now < MIN_DT_US) begin
						k_q <= '0;
						state_q <= ST_MDIV;
					end else begin
						last_time_q <= req_q.time_us;
						accepted_q <= 1'b1;
						state_q <= ST_XMUL;
					end
				end
				ST_XMUL: begin
					if (fin) begin
						x_q <= ar_rsp.res[53:23];
						p_q <= 32'h4000_0000;
						sin_q <= '0;
						cos_q <= 34'sh0_4000_0000;
						n_q <= 5'd1;
						state_q <= ST_TMUL;
					end
				end
				ST_TMUL: begin
					if (fin) begin
						tmp_q <= ar_rsp.res;
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (fin) begin
						p_q <= p_new;
						if (n_q[0]) sin_q <= sin_q + term;
						else cos_q <= cos_q + term;
						if (n_q == 5'd16) begin
							state_q <= ST_FOLD;
						end else begin
							n_q <= n_q + 5'd1;
							state_q <= ST_TMUL;
						end
					end
				end
				ST_FOLD: begin
					// quadrant fold of the first-quadrant series
					case (heading_q[23:22])
						2'd0: begin
							sin_q <= sin_q;
							cos_q <= cos_q;
						end
						2'd1: begin
							sin_q <= cos_q;
							cos_q <= -sin_q;
						end
						2'd2: begin
							sin_q <= -sin_q;
							cos_q <= -cos_q;
						end
						default: begin
							sin_q <= -cos_q;
							cos_q <= sin_q;
						end
					endcase
					k_q <= '0;
					state_q <= ST_RMUL;
				end
				ST_RMUL: begin
					if (fin) begin
						case (k_q)
							2'd0: tmp_q <= ar_rsp.res;
							2'd1: pose_x_q <= pose_new;
							2'd2: tmp_q <= ar_rsp.res;
							default: begin
								pose_y_q <= pose_new;
								heading_q <= heading_q + hstep_q;
							end
						endcase
						if (k_q == 2'd3) begin
							k_q <= '0;
							state_q <= ST_SMUL;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				ST_SMUL: begin
					if (fin) begin
						tmp_q <= ar_rsp.res;
						state_q <= ST_SDIV;
					end
				end
				ST_SDIV: begin
					if (fin) begin
						smp_q[k_q] <= sat32(ar_rsp.res);
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= ST_RDREQ;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= ST_SMUL;
						end
					end
				end
				ST_RDREQ: begin
					// ring read of the oldest sample, data back next cycle
					idx_q <= idx_norm;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					for (int i = 0; i < 3; i++) begin
						sums_q[i] <= sums_q[i]
							- (full ? SW'(signed'(ring_rdata[i])) : SW'(0))
							+ SW'(smp_q[i]);
					end
					if (!full) count_q <= count_q + CW'(1);
					idx_q <= idx_next;
					k_q <= '0;
					state_q <= ST_MDIV;
				end
				ST_MDIV: begin
					if (count_q == '0 || fin) begin
						mean_q[k_q] <= (count_q == '0) ? 32'sd0 : sat32(ar_rsp.res);
						if (k_q == 2'd2) begin
							k_q <= '0;
							state_q <= ST_DONE;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q.accepted <= accepted_q;
						out_q.pos_x <= pose_x_q;
						out_q.pos_y <= pose_y_q;
						out_q.heading_angle <= heading_q;
						out_q.speed_x <= mean_q[0];
						out_q.speed_y <= mean_q[1];
						out_q.turn_rate <= mean_q[2];
						out_q.travel_a <= travel_q[0];
						out_q.travel_b <= travel_q[1];
						out_q.travel_c <= travel_q[2];
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// register writes, to be made only while idle; the block does not enforce it
			if (cfg_we) begin
				case (cfg_index)
					REG_WHEEL_RADIUS: radius_q <= cfg_data;
					REG_CENTER_DIST: center_q <= cfg_data;
					REG_WINDOW_LEN: begin
						window_q <= cfg_data[6:0];
						for (int i = 0; i < 3; i++) sums_q[i] <= '0;
						count_q <= '0;
						idx_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

### tb/testbench.sv
// self-checking testbench for the three-wheel omni odometry block
module testbench;
	import twod_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_MAX = 64;
	localparam longint CYCLE_LIMIT = 80000000;
	localparam int HOLDOFF_CYCLES = 20000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	twod_stream_if #(.payload_t(wheel_req_t)) wheel_ch ();
	twod_stream_if #(.payload_t(odom_rsp_t)) odom_ch ();

	three_wheel_omni_odometry #(.WINDOW_MAX(WIN_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.wheel(wheel_ch.sink),
		.odom(odom_ch.source)
	);

	// clock, 2 ns period
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// shadow configuration of the predictor
	logic [15:0] m_radius;
	logic [15:0] m_center;
	logic [6:0] m_window;

	// shadow state of the predictor
	logic signed [31:0] m_pos_x;
	logic signed [31:0] m_pos_y;
	logic [23:0] m_heading;
	logic signed [31:0] m_travel [3];
	logic [31:0] m_last_time;
	int m_ring [3][WIN_MAX];
	longint m_sums [3];
	int m_count;
	int m_ring_pos;

	// results that the block still owes, oldest first
	odom_rsp_t odom_expected [$];

	int mismatches;
	int results_seen;
	int requests_sent;
	int accepted_seen;
	longint cycles;

	// idling control
	int send_idle_pct;
	int recv_stall_pct;
	bit holdoff_pending;
	int holdoff_left;

	function automatic longint div_rnd(longint n, longint d);
		longint m;
		longint q;
		m = (n < 0) ? -n : n;
		q = (m + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint shr_rnd(longint x, int s);
		return (x + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// truncated taylor sine/cosine in q30, folded by quadrant
	task automatic heading_sin_cos(input logic [23:0] h, output longint sn, output longint cs);
		longint unsigned x;
		longint unsigned p;
		longint s;
		longint c;
		x = ({42'd0, h[21:0]} * 64'd3373259426) >> 23;
		p = 64'd1 << 30;
		s = 0;
		c = longint'(p);
		for (int n = 1; n <= 16; n++) begin
			p = ((p * x) >> 30) / n;
			if (n % 2 == 1) begin
				s += ((n >> 1) & 1) ? -longint'(p) : longint'(p);
			end else begin
				c += ((n >> 1) & 1) ? -longint'(p) : longint'(p);
			end
		end
		case (h[23:22])
			2'd0: begin sn = s; cs = c; end
			2'd1: begin sn = c; cs = -s; end
			2'd2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endtask

	function automatic int window_in_use();
		if (m_window < 1) return 1;
		if (m_window > WIN_MAX) return WIN_MAX;
		return int'(m_window);
	endfunction

	function automatic void means_clear();
		for (int k = 0; k < 3; k++) m_sums[k] = 0;
		m_count = 0;
		m_ring_pos = 0;
	endfunction

	// new speed samples into the rolling window
	function automatic void means_push(longint s0, longint s1, longint s2);
		int w;
		longint smp [3];
		w = window_in_use();
		smp[0] = s0;
		smp[1] = s1;
		smp[2] = s2;
		if (m_ring_pos >= w) m_ring_pos = 0;
		for (int k = 0; k < 3; k++) begin
			if (m_count >= w) m_sums[k] -= m_ring[k][m_ring_pos];
			m_ring[k][m_ring_pos] = int'(smp[k]);
			m_sums[k] += smp[k];
		end
		if (m_count < w) m_count++;
		m_ring_pos = (m_ring_pos + 1 >= w) ? 0 : m_ring_pos + 1;
	endfunction

	function automatic void odom_reset_state();
		m_radius = '0;
		m_center = '0;
		m_window = 7'd16;
		m_pos_x = '0;
		m_pos_y = '0;
		m_heading = '0;
		for (int k = 0; k < 3; k++) m_travel[k] = '0;
		m_last_time = '0;
		means_clear();
	endfunction

	function automatic void odom_config(logic [1:0] idx, logic [15:0] data);
		case (idx)
			REG_WHEEL_RADIUS: m_radius = data;
			REG_CENTER_DIST: m_center = data;
			REG_WINDOW_LEN: begin
				m_window = data[6:0];
				means_clear();
			end
			default: ;
		endcase
	endfunction

	// advance the shadow state by one request and form its result
	task automatic odom_predict(input wheel_req_t q, output odom_rsp_t r);
		longint rad;
		longint len;
		longint v1;
		longint v2;
		longint v3;
		longint dx;
		longint dy;
		longint sum;
		longint dth;
		longint hstep;
		longint sn;
		longint cs;
		logic [31:0] dt;
		bit acc;
		acc = 1'b0;
		if (q.operation == OP_INIT) begin
			means_clear();
			m_last_time = q.time_us;
		end else begin
			rad = longint'(m_radius);
			len = longint'(m_center);
			// wheel reorder: first = b, second = c, third = a
			v1 = shr_rnd(longint'(q.wheel_b_step) * rad, FRAC_BITS);
			v2 = shr_rnd(longint'(q.wheel_c_step) * rad, FRAC_BITS);
			v3 = shr_rnd(longint'(q.wheel_a_step) * rad, FRAC_BITS);
			m_travel[0] = m_travel[0] + v1[31:0];
			m_travel[1] = m_travel[1] + v2[31:0];
			m_travel[2] = m_travel[2] + v3[31:0];
			dx = shr_rnd((v1 - v2) * 64'sd2479700525, 32);
			dy = div_rnd(v1 + v2 - 2 * v3, 3);
			sum = v1 + v2 + v3;
			dth = 0;
			hstep = 0;
			// zero wheel center leaves the heading alone
			if (len != 0) begin
				dth = div_rnd(sum * (64'sd1 <<< FRAC_BITS), 3 * len);
				hstep = div_rnd(sum * 64'sd42722830, 48 * len);
			end
			dt = q.time_us - m_last_time;
			if (dt >= MIN_DT_US) begin
				m_last_time = q.time_us;
				heading_sin_cos(m_heading, sn, cs);
				m_pos_x = 32'(clamp32(longint'(m_pos_x) + shr_rnd(dx * cs - dy * sn, 30)));
				m_pos_y = 32'(clamp32(longint'(m_pos_y) + shr_rnd(dy * cs + dx * sn, 30)));
				m_heading = m_heading + hstep[23:0];
				means_push(clamp32(div_rnd(dx * 1000000, {32'd0, dt})),
					clamp32(div_rnd(dy * 1000000, {32'd0, dt})),
					clamp32(div_rnd(dth * 1000000, {32'd0, dt})));
				acc = 1'b1;
			end
		end
		r.accepted = acc;
		r.pos_x = m_pos_x;
		r.pos_y = m_pos_y;
		r.heading_angle = m_heading;
		r.speed_x = m_count ? 32'(clamp32(div_rnd(m_sums[0], m_count))) : '0;
		r.speed_y = m_count ? 32'(clamp32(div_rnd(m_sums[1], m_count))) : '0;
		r.turn_rate = m_count ? 32'(clamp32(div_rnd(m_sums[2], m_count))) : '0;
		r.travel_a = m_travel[0];
		r.travel_b = m_travel[1];
		r.travel_c = m_travel[2];
	endtask

	// directed stimulus table
	typedef struct {
		logic op;
		int a;
		int b;
		int c;
		logic [31:0] t;
		bit known;
		bit known_acc;
	} odom_row_t;

	localparam int ROWS = 22;
	odom_row_t rows [ROWS];

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				odom_expected.size());
			$display("FAIL three_wheel_omni_odometry");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(negedge clk) begin
		if (holdoff_pending) begin
			holdoff_pending = 1'b0;
			holdoff_left = HOLDOFF_CYCLES;
		end
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			odom_ch.ready = 1'b0;
		end else begin
			odom_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor: compare against the oldest owed result
	always @(posedge clk) begin
		odom_rsp_t got;
		odom_rsp_t want;
		if (arst_n && odom_ch.valid && odom_ch.ready) begin
			got = odom_ch.payload;
			results_seen++;
			if (odom_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				want = odom_expected.pop_front();
				if (got.accepted !== want.accepted || got.pos_x !== want.pos_x ||
					got.pos_y !== want.pos_y || got.heading_angle !== want.heading_angle ||
					got.speed_x !== want.speed_x || got.speed_y !== want.speed_y ||
					got.turn_rate !== want.turn_rate || got.travel_a !== want.travel_a ||
					got.travel_b !== want.travel_b || got.travel_c !== want.travel_c) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d at cycle %0d", results_seen, cycles);
						$display("  exp acc %0d x %h y %h hd %h sx %h sy %h tr %h ta %h tb %h tc %h",
							want.accepted, want.pos_x, want.pos_y, want.heading_angle,
							want.speed_x, want.speed_y, want.turn_rate, want.travel_a,
							want.travel_b, want.travel_c);
						$display("  got acc %0d x %h y %h hd %h sx %h sy %h tr %h ta %h tb %h tc %h",
							got.accepted, got.pos_x, got.pos_y, got.heading_angle,
							got.speed_x, got.speed_y, got.turn_rate, got.travel_a,
							got.travel_b, got.travel_c);
					end
				end
			end
		end
	end

	// offer one request at a falling edge, hold it until taken
	task automatic send_request(input wheel_req_t q, input bit use_table, input odom_rsp_t typed);
		odom_rsp_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			wheel_ch.valid = 1'b0;
			@(negedge clk);
		end
		wheel_ch.valid = 1'b1;
		wheel_ch.payload = q;
		do @(posedge clk); while (!wheel_ch.ready);
		odom_predict(q, r);
		odom_expected.push_back(use_table ? typed : r);
		requests_sent++;
		if (r.accepted) accepted_seen++;
		@(negedge clk);
	endtask

	task automatic drain();
		wheel_ch.valid = 1'b0;
		while (odom_expected.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// register write at a falling edge, block is idle here
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		odom_config(idx, data);
	endtask

	task automatic configure(input logic [15:0] rad, input logic [15:0] len,
		input logic [15:0] win);
		drain();
		write_reg(REG_WHEEL_RADIUS, rad);
		write_reg(REG_CENTER_DIST, len);
		write_reg(REG_WINDOW_LEN, win);
	endtask

	function automatic odom_row_t mk_row(logic op, int a, int b, int c, logic [31:0] t);
		odom_row_t w;
		w.op = op;
		w.a = a;
		w.b = b;
		w.c = c;
		w.t = t;
		w.known = 1'b0;
		w.known_acc = 1'b0;
		return w;
	endfunction

	function automatic wheel_req_t row_req(odom_row_t w);
		wheel_req_t q;
		q.operation = w.op;
		q.wheel_a_step = w.a[19:0];
		q.wheel_b_step = w.b[19:0];
		q.wheel_c_step = w.c[19:0];
		q.time_us = w.t;
		return q;
	endfunction

	function automatic int rand_step();
		int s;
		if ($urandom_range(1)) s = int'($urandom_range(20'hfffff));
		else s = int'($urandom_range(4000)) - 2000;
		return s;
	endfunction

	initial begin
		wheel_req_t q;
		odom_rsp_t typed;
		logic [31:0] t_now;
		int pick;
		int phase_items;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		wheel_ch.valid = 1'b0;
		wheel_ch.payload = '0;
		odom_ch.ready = 1'b0;
		cycles = 0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		accepted_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_pending = 1'b0;
		holdoff_left = 0;
		odom_reset_state();

		// rows 0..2: reset config, radius 0, so all outputs read zero but the accepted flag of row 1
		rows[0] = mk_row(OP_UPDATE, 524287, -524288, 524287, 32'd50);
		rows[0].known = 1'b1;
		rows[1] = mk_row(OP_UPDATE, -524288, 524287, -524288, 32'd200);
		rows[1].known = 1'b1;
		rows[1].known_acc = 1'b1;
		rows[2] = mk_row(OP_INIT, 0, 0, 0, 32'd300);
		rows[2].known = 1'b1;
		// rows 3..14: radius and center at maximum, window 2
		rows[3] = mk_row(OP_UPDATE, 524287, 524287, 524287, 32'd400);
		rows[4] = mk_row(OP_UPDATE, -524288, -524288, -524288, 32'd499);
		rows[5] = mk_row(OP_UPDATE, 0, 524287, -524288, 32'd600);
		rows[6] = mk_row(OP_UPDATE, 1, -1, 1, 32'd700);
		rows[7] = mk_row(OP_UPDATE, 131072, 0, 0, 32'd900);
		rows[8] = mk_row(OP_UPDATE, 0, 0, 0, 32'd1000);
		rows[9] = mk_row(OP_UPDATE, 262144, 262144, 262144, 32'd1100);
		// timestamp going back wraps to a long interval
		rows[10] = mk_row(OP_UPDATE, -1000, 5000, 2000, 32'd10);
		rows[11] = mk_row(OP_INIT, 0, 0, 0, 32'hffffffc0);
		// interval wraps through zero, exactly the minimum
		rows[12] = mk_row(OP_UPDATE, 300000, -300000, 12345, 32'h00000024);
		rows[13] = mk_row(OP_UPDATE, 77, 88, 99, 32'h00000050);
		rows[14] = mk_row(OP_UPDATE, -524288, 524287, 0, 32'hffffffff);
		// rows 15..21: zero wheel center, window field 0 acts as one
		rows[15] = mk_row(OP_UPDATE, 524287, 524287, 524287, 32'h00000100);
		rows[16] = mk_row(OP_UPDATE, 100000, -50000, 25000, 32'h00000200);
		rows[17] = mk_row(OP_UPDATE, -524288, -524288, -524288, 32'h00000300);
		rows[18] = mk_row(OP_INIT, 0, 0, 0, 32'h00000400);
		rows[19] = mk_row(OP_UPDATE, 4000, 4000, -4000, 32'h00000463);
		rows[20] = mk_row(OP_UPDATE, 4000, 4000, -4000, 32'h00000464);
		rows[21] = mk_row(OP_UPDATE, 1, 2, 3, 32'h12345678);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (5) @(negedge clk);

		// directed part, no idling
		for (int i = 0; i < ROWS; i++) begin
			if (i == 3) configure(16'hffff, 16'hffff, 16'd2);
			if (i == 15) begin
				configure(16'h8000, 16'h0000, 16'hff80);
				// unknown register index is ignored
				write_reg(2'd3, 16'hffff);
			end
			typed = '0;
			typed.accepted = rows[i].known_acc;
			send_request(row_req(rows[i]), rows[i].known, typed);
		end

		// random part: eight phases over settings and idling modes
		t_now = 32'h20000000;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: configure(16'h4000, 16'h2000, 16'd16);
				1: configure(16'hffff, 16'hffff, 16'd64);
				2: configure(16'd1, 16'd1, 16'd1);
				3: configure(16'($urandom), 16'h0000, 16'h007f);
				4: configure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 64)));
				5: configure(16'h0000, 16'hffff, 16'd8);
				6: configure(16'h8000, 16'h0400, 16'hffc3);
				default: configure(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 62; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 62; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			// long receiver hold-off while requests keep coming
			if (ph == 2 || ph == 5) holdoff_pending = 1'b1;
			phase_items = 250;
			for (int n = 0; n < phase_items; n++) begin
				pick = $urandom_range(99);
				if (pick < 70) t_now = t_now + $urandom_range(100, 3000);
				else if (pick < 85) t_now = t_now + $urandom_range(0, 99);
				else if (pick < 90) t_now = $urandom;
				else t_now = t_now + $urandom_range(100, 200000);
				q.operation = ($urandom_range(99) < 7) ? OP_INIT : OP_UPDATE;
				q.wheel_a_step = 20'(rand_step());
				q.wheel_b_step = 20'(rand_step());
				q.wheel_c_step = 20'(rand_step());
				q.time_us = t_now;
				send_request(q, 1'b0, typed);
			end
		end

		drain();
		holdoff_left = 0;
		repeat (3000) @(posedge clk);

		$display("sent %0d requests (%0d updates accepted), checked %0d results", requests_sent,
			accepted_seen, results_seen);
		$display("covered field extremes, init, short and wrapped intervals, eight settings");
		if (mismatches == 0 && odom_expected.size() == 0) begin
			$display("PASS three_wheel_omni_odometry");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, odom_expected.size());
			$display("FAIL three_wheel_omni_odometry");
		end
		$finish;
	end

endmodule

### sim.f
rtl/twod_pkg.sv
rtl/twod_stream_if.sv
rtl/twod_ram.sv
rtl/twod_arith.sv
rtl/three_wheel_omni_odometry.sv
tb/testbench.sv
